// File: src/vics_pkg.sv
// shared types and constants for the velocity integrator with speed clamp
// no dependencies; every other file refers to it by scoped names
package vics_pkg;

    localparam int unsigned DATA_W    = 32;  // signed Q16.16 words
    localparam int unsigned FRAC_W    = 16;  // fraction bits of Q16.16
    localparam int unsigned DT_W      = 16;  // unsigned Q0.16 tick duration
    localparam int unsigned UREG_W    = 31;  // inv_mass and speed_limit
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CNT_W     = 5;   // 32 steps of sqrt and divide

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_X     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_Y     = CFG_IDX_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_IMPULSE   = 2'd1,
        CMD_ADD_VEL   = 2'd2,
        CMD_RESET_VEL = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_ACC,
        S_DV,
        S_VEL,
        S_SQR,
        S_CMP,
        S_SQRT,
        S_SCALE,
        S_DIV,
        S_FIX,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ITEM,
        OP_SUM,
        OP_ACC,
        OP_DV,
        OP_VEL,
        OP_SQR,
        OP_CMP,
        OP_SQRT,
        OP_SCALE,
        OP_DIV,
        OP_FIX,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic over_limit;  // squared speed above squared limit
        logic cnt_done;    // last step of sqrt or divide
        logic out_busy;    // output register full and not taken
    } t_dp_status;

endpackage

// File: src/vics_if.sv
// valid/ready channel interfaces: input items, result items, config writes
// depends on vics_pkg for field widths
interface vics_in_if;
    logic                          valid;
    logic                          ready;
    logic [vics_pkg::CMD_W-1:0]    cmd;
    logic signed [vics_pkg::DATA_W-1:0] vec_x;
    logic signed [vics_pkg::DATA_W-1:0] vec_y;
    logic [vics_pkg::DT_W-1:0]     delta_time;

    modport source (output valid, cmd, vec_x, vec_y, delta_time, input ready);
    modport sink   (input valid, cmd, vec_x, vec_y, delta_time, output ready);
endinterface

interface vics_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [vics_pkg::DATA_W-1:0] displacement_x;
    logic signed [vics_pkg::DATA_W-1:0] displacement_y;
    logic signed [vics_pkg::DATA_W-1:0] speed_x;
    logic signed [vics_pkg::DATA_W-1:0] speed_y;
    logic                               clamped;

    modport source (output valid, displacement_x, displacement_y, speed_x, speed_y,
                    clamped, input ready);
    modport sink   (input valid, displacement_x, displacement_y, speed_x, speed_y,
                    clamped, output ready);
endinterface

interface vics_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vics_pkg::CFG_IDX_W-1:0]   index;
    logic [vics_pkg::DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/vics_ctrl.sv
// sequencer for the integrator: walks a tick through the datapath steps
// depends on vics_pkg (state, datapath op and status types)
module vics_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [vics_pkg::CMD_W-1:0]     i_in_cmd,
    input  vics_pkg::t_dp_status           i_status,
    output logic                           o_in_ready,
    output vics_pkg::t_dp_op               o_op
);

    vics_pkg::t_state r_state;
    vics_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vics_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vics_pkg::S_IDLE: begin
                if (i_in_valid && (i_in_cmd == vics_pkg::CMD_TICK)) begin
                    n_state = vics_pkg::S_SUM;
                end
            end
            vics_pkg::S_SUM:   n_state = vics_pkg::S_ACC;
            vics_pkg::S_ACC:   n_state = vics_pkg::S_DV;
            vics_pkg::S_DV:    n_state = vics_pkg::S_VEL;
            vics_pkg::S_VEL:   n_state = vics_pkg::S_SQR;
            vics_pkg::S_SQR:   n_state = vics_pkg::S_CMP;
            vics_pkg::S_CMP: begin
                n_state = i_status.over_limit ? vics_pkg::S_SQRT : vics_pkg::S_EMIT;
            end
            vics_pkg::S_SQRT: begin
                if (i_status.cnt_done) begin
                    n_state = vics_pkg::S_SCALE;
                end
            end
            vics_pkg::S_SCALE: n_state = vics_pkg::S_DIV;
            vics_pkg::S_DIV: begin
                if (i_status.cnt_done) begin
                    n_state = vics_pkg::S_FIX;
                end
            end
            vics_pkg::S_FIX:   n_state = vics_pkg::S_EMIT;
            vics_pkg::S_EMIT: begin
                if (!i_status.out_busy) begin
                    n_state = vics_pkg::S_IDLE;
                end
            end
            default:           n_state = vics_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = vics_pkg::OP_NONE;
        case (r_state)
            vics_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_op       = i_in_valid ? vics_pkg::OP_ITEM : vics_pkg::OP_NONE;
            end
            vics_pkg::S_SUM:   o_op = vics_pkg::OP_SUM;
            vics_pkg::S_ACC:   o_op = vics_pkg::OP_ACC;
            vics_pkg::S_DV:    o_op = vics_pkg::OP_DV;
            vics_pkg::S_VEL:   o_op = vics_pkg::OP_VEL;
            vics_pkg::S_SQR:   o_op = vics_pkg::OP_SQR;
            vics_pkg::S_CMP:   o_op = vics_pkg::OP_CMP;
            vics_pkg::S_SQRT:  o_op = vics_pkg::OP_SQRT;
            vics_pkg::S_SCALE: o_op = vics_pkg::OP_SCALE;
            vics_pkg::S_DIV:   o_op = vics_pkg::OP_DIV;
            vics_pkg::S_FIX:   o_op = vics_pkg::OP_FIX;
            vics_pkg::S_EMIT: begin
                o_op = i_status.out_busy ? vics_pkg::OP_NONE : vics_pkg::OP_EMIT;
            end
            default:           o_op = vics_pkg::OP_NONE;
        endcase
    end

endmodule

// File: src/vics_dp.sv
// datapath: config and body state, per-axis multipliers, bit-serial sqrt
// and two bit-serial dividers, output register; depends on vics_pkg
module vics_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vics_pkg::t_dp_op                    i_op,
    output vics_pkg::t_dp_status                o_status,
    // input payload
    input  logic [vics_pkg::CMD_W-1:0]          i_in_cmd,
    input  logic signed [vics_pkg::DATA_W-1:0]  i_in_vec_x,
    input  logic signed [vics_pkg::DATA_W-1:0]  i_in_vec_y,
    input  logic [vics_pkg::DT_W-1:0]           i_in_delta_time,
    // config writes
    input  logic                                i_cfg_we,
    input  logic [vics_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vics_pkg::DATA_W-1:0]         i_cfg_data,
    // result register
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [vics_pkg::DATA_W-1:0]  o_disp_x,
    output logic signed [vics_pkg::DATA_W-1:0]  o_disp_y,
    output logic signed [vics_pkg::DATA_W-1:0]  o_speed_x,
    output logic signed [vics_pkg::DATA_W-1:0]  o_speed_y,
    output logic                                o_clamped
);

    localparam int unsigned DW  = vics_pkg::DATA_W;
    localparam int unsigned FW  = vics_pkg::FRAC_W;
    localparam int unsigned TW  = 48;       // accel and velocity change width
    localparam int unsigned SW  = 49;       // widest sum before saturation
    localparam int unsigned PW  = 2 * DW;   // product and squared length width
    localparam int unsigned UW  = vics_pkg::UREG_W;
    localparam int unsigned CW  = vics_pkg::CNT_W;

    function automatic logic signed [DW-1:0] f_sat(input logic signed [SW-1:0] v);
        logic ovf;
        ovf = (v[SW-1:DW-1] != {(SW-DW+1){v[SW-1]}});
        if (!ovf) begin
            return v[DW-1:0];
        end
        return v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    // configuration and body state
    logic [UW-1:0]          r_inv_mass;
    logic [UW-1:0]          r_speed_limit;
    logic signed [DW-1:0]   r_force [2];
    logic signed [DW-1:0]   r_vel   [2];
    logic signed [DW-1:0]   r_pend  [2];
    logic                   r_out_valid;

    // working registers
    logic [vics_pkg::DT_W-1:0] r_dt;
    logic signed [TW-1:0]   r_t    [2];   // sum, then accel, then velocity change
    logic [DW-1:0]          r_mv   [2];   // velocity magnitudes
    logic [PW-1:0]          r_sq   [2];
    logic [PW-1:0]          r_lim2;
    logic                   r_clamp;
    logic [PW-1:0]          r_rem;
    logic [PW-1:0]          r_root;
    logic [CW-1:0]          r_cnt;
    logic [DW-1:0]          r_mag;
    logic [DW-1:0]          r_drem [2];
    logic [DW-1:0]          r_dq   [2];   // dividend low half, then quotient
    logic signed [DW-1:0]   r_o_disp  [2];
    logic signed [DW-1:0]   r_o_speed [2];
    logic                   r_o_clamp;

    logic signed [DW-1:0]   w_vec   [2];
    logic signed [DW-1:0]   w_s     [2];
    logic signed [PW-1:0]   w_pacc  [2];
    logic signed [PW-1:0]   w_pdv   [2];
    logic signed [DW-1:0]   w_vnew  [2];
    logic signed [DW-1:0]   w_vadd  [2];
    logic signed [DW-1:0]   w_pnew  [2];
    logic [DW-1:0]          w_mv    [2];
    logic [PW-1:0]          w_sq    [2];
    logic [PW-1:0]          w_num   [2];
    logic [DW:0]            w_drem2 [2];
    logic [DW:0]            w_ddiff [2];
    logic                   w_dge   [2];
    logic signed [DW-1:0]   w_fix   [2];
    logic signed [TW-1:0]   w_pdisp [2];
    logic [PW-1:0]          w_lim2;
    logic [PW-1:0]          w_len2;
    logic [PW-1:0]          w_bit;
    logic [PW-1:0]          w_trial;
    logic                   w_sge;
    logic [DW-1:0]          w_mag;

    assign w_vec[0] = i_in_vec_x;
    assign w_vec[1] = i_in_vec_y;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_s[i]     = f_sat(SW'(r_force[i]) + SW'(r_pend[i]));
            w_pnew[i]  = f_sat(SW'(r_pend[i]) + SW'(w_vec[i]));
            w_vadd[i]  = f_sat(SW'(r_vel[i]) + SW'(w_vec[i]));
            w_pacc[i]  = $signed(r_t[i][DW-1:0]) * $signed({1'b0, r_inv_mass});
            w_pdv[i]   = r_t[i] * $signed({1'b0, r_dt});
            w_vnew[i]  = f_sat(SW'(r_vel[i]) + SW'(r_t[i]));
            w_mv[i]    = r_vel[i][DW-1] ? DW'(-r_vel[i]) : DW'(r_vel[i]);
            w_sq[i]    = {{DW{1'b0}}, w_mv[i]} * {{DW{1'b0}}, w_mv[i]};
            w_num[i]   = {{DW{1'b0}}, r_mv[i]} * {{(PW-UW){1'b0}}, r_speed_limit};
            w_drem2[i] = {r_drem[i], r_dq[i][DW-1]};
            w_ddiff[i] = w_drem2[i] - {1'b0, r_mag};
            w_dge[i]   = (w_drem2[i] >= {1'b0, r_mag});
            // quotient never exceeds the limit, so restoring the sign cannot overflow
            w_fix[i]   = f_sat(r_vel[i][DW-1] ? -SW'(r_dq[i]) : SW'(r_dq[i]));
            w_pdisp[i] = r_vel[i] * $signed({1'b0, r_dt});
        end
    end

    assign w_lim2  = {{(PW-UW){1'b0}}, r_speed_limit} * {{(PW-UW){1'b0}}, r_speed_limit};
    assign w_len2  = r_sq[0] + r_sq[1];
    assign w_bit   = PW'(1) << {r_cnt, 1'b0};
    assign w_trial = r_root + w_bit;
    assign w_sge   = (r_rem >= w_trial);
    assign w_mag   = (r_root[DW-1:0] == '0) ? DW'(1) : r_root[DW-1:0];

    assign o_status.over_limit = (w_len2 > r_lim2);
    assign o_status.cnt_done   = (r_cnt == '0);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    // architectural state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass    <= '0;
            r_speed_limit <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_force[i] <= '0;
                r_vel[i]   <= '0;
                r_pend[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vics_pkg::REG_INV_MASS:    r_inv_mass    <= i_cfg_data[UW-1:0];
                    vics_pkg::REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[UW-1:0];
                    vics_pkg::REG_FORCE_X:     r_force[0]    <= i_cfg_data;
                    vics_pkg::REG_FORCE_Y:     r_force[1]    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_op == vics_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            for (int i = 0; i < 2; i++) begin
                case (i_op)
                    vics_pkg::OP_ITEM: begin
                        case (i_in_cmd)
                            vics_pkg::CMD_IMPULSE:   r_pend[i] <= w_pnew[i];
                            vics_pkg::CMD_ADD_VEL:   r_vel[i]  <= w_vadd[i];
                            vics_pkg::CMD_RESET_VEL: r_vel[i]  <= '0;
                            default: ;
                        endcase
                    end
                    vics_pkg::OP_SUM: r_pend[i] <= '0;
                    vics_pkg::OP_VEL: r_vel[i]  <= w_vnew[i];
                    vics_pkg::OP_FIX: r_vel[i]  <= w_fix[i];
                    default: ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_op)
            vics_pkg::OP_ITEM: r_dt <= i_in_delta_time;
            vics_pkg::OP_SQR:  r_lim2 <= w_lim2;
            vics_pkg::OP_CMP: begin
                r_clamp <= o_status.over_limit;
                r_rem   <= w_len2;
                r_root  <= '0;
                r_cnt   <= '1;
            end
            vics_pkg::OP_SQRT: begin
                if (w_sge) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
            vics_pkg::OP_SCALE: begin
                r_mag <= w_mag;
                r_cnt <= '1;
            end
            vics_pkg::OP_DIV:  r_cnt <= r_cnt - CW'(1);
            vics_pkg::OP_EMIT: r_o_clamp <= r_clamp;
            default: ;
        endcase

        for (int i = 0; i < 2; i++) begin
            case (i_op)
                vics_pkg::OP_SUM: r_t[i]  <= TW'(w_s[i]);
                vics_pkg::OP_ACC: r_t[i]  <= w_pacc[i][PW-1:FW];
                vics_pkg::OP_DV:  r_t[i]  <= w_pdv[i][PW-1:FW];
                vics_pkg::OP_SQR: begin
                    r_mv[i] <= w_mv[i];
                    r_sq[i] <= w_sq[i];
                end
                vics_pkg::OP_SCALE: begin
                    r_drem[i] <= w_num[i][PW-1:DW];
                    r_dq[i]   <= w_num[i][DW-1:0];
                end
                vics_pkg::OP_DIV: begin
                    r_drem[i] <= w_dge[i] ? w_ddiff[i][DW-1:0] : w_drem2[i][DW-1:0];
                    r_dq[i]   <= {r_dq[i][DW-2:0], w_dge[i]};
                end
                vics_pkg::OP_EMIT: begin
                    // |v * dt| stays below 2^47, so the shifted product fits
                    r_o_disp[i]  <= w_pdisp[i][TW-1:FW];
                    r_o_speed[i] <= r_vel[i];
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_disp_x    = r_o_disp[0];
    assign o_disp_y    = r_o_disp[1];
    assign o_speed_x   = r_o_speed[0];
    assign o_speed_y   = r_o_speed[1];
    assign o_clamped   = r_o_clamp;

endmodule

// File: src/velocity_integrator_speed_clamp_top.sv
// a non-tick command takes effect at its accepting edge; a tick walks the sum, accel,
// velocity change, velocity, square and compare steps, then emit, or when the speed
// limit clamps first a 32-step square root, scale, 32-step divide and fix; an unread
// earlier result holds the emit step, and the sequencer walks one item at a time
// reset: i_rst_n is synchronous, active low; clears config, velocity, pending impulses,
// the sequencer and the result valid
// top level: ties channel interfaces to the sequencer and the datapath
// depends on vics_pkg, vics_if, vics_ctrl, vics_dp
module velocity_integrator_speed_clamp_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vics_in_if.sink    i_in,
    vics_cfg_if.sink   i_cfg,
    vics_out_if.source o_out
);

    logic                 w_in_ready;
    vics_pkg::t_dp_op     w_op;
    vics_pkg::t_dp_status w_status;

    // config always taken, unchecked; source must send writes only with nothing in flight
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    // sequencer: one tick at a time, other commands finish in the accept cycle
    vics_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_op       (w_op)
    );

    // datapath: state, integrate, clamp, and the result register that holds a
    // finished transaction while the sequencer goes back to accepting input
    vics_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .o_status        (w_status),
        .i_in_cmd        (i_in.cmd),
        .i_in_vec_x      (i_in.vec_x),
        .i_in_vec_y      (i_in.vec_y),
        .i_in_delta_time (i_in.delta_time),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_disp_x        (o_out.displacement_x),
        .o_disp_y        (o_out.displacement_y),
        .o_speed_x       (o_out.speed_x),
        .o_speed_y       (o_out.speed_y),
        .o_clamped       (o_out.clamped)
    );

endmodule

// File: src/vics_chk.sv
// port-level checker for the integrator top, attached by bind
// depends on vics_pkg and the top level's ports
module vics_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [vics_pkg::CMD_W-1:0]    i_in_cmd,
    input logic                          i_cfg_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [vics_pkg::DATA_W-1:0]   i_out_disp_x,
    input logic [vics_pkg::DATA_W-1:0]   i_out_speed_x
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_disp_x) && $stable(i_out_speed_x))
        else $error("result payload changed while stalled");

    // a tick holds off further input once it is accepted
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == vics_pkg::CMD_TICK) |=> !i_in_ready)
        else $error("input taken during a tick");

    // other commands finish in the accept cycle
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd != vics_pkg::CMD_TICK) |=> i_in_ready)
        else $error("non-tick command stalled input");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind velocity_integrator_speed_clamp_top vics_chk u_vics_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_cmd      (i_in.cmd),
    .i_cfg_ready   (i_cfg.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_disp_x  (o_out.displacement_x),
    .i_out_speed_x (o_out.speed_x)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// testbench for velocity_integrator_speed_clamp_top: directed and random command traffic
// checked against a built-in predictor of the body state; depends on vics_pkg and vics_if
module tb_top;

    localparam int     STALL_LIMIT = 3000;  // cycles with no transaction before giving up
    localparam int     IDLE_PAUSE  = 12;    // settle time before config writes
    localparam int     DRAIN_PAUSE = 20;    // settle time after the last result
    localparam int     MAX_PRINT   = 50;    // cap on reported mismatches
    localparam int     PHASES      = 8;
    localparam int     PHASE_ITEMS = 130;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;  // 1.0 in Q16.16
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam logic [30:0]        UMAX = 31'h7FFF_FFFF;

    typedef bit [63:0] t_u64;

    // one tick result as the block should report it
    typedef struct packed {
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] spd_x;
        logic signed [31:0] spd_y;
        logic               clamped;
    } t_motion;

    logic i_clk;
    logic i_rst_n;

    vics_in_if  in_if ();
    vics_cfg_if cfg_if ();
    vics_out_if out_if ();

    velocity_integrator_speed_clamp_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // predicted body state and register copies
    logic [30:0]        m_inv_mass;
    logic [30:0]        m_limit;
    logic signed [31:0] m_force_x;
    logic signed [31:0] m_force_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] imp_x;
    logic signed [31:0] imp_y;

    t_motion motion_q[$];   // tick results still owed by the block
    int      mismatches;
    int      items_sent;
    bit      send_gaps_on;
    bit      sink_stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] sat_word(input longint v);
        if (v > WORD_MAX) return SMAX;
        if (v < WORD_MIN) return SMIN;
        return v[31:0];
    endfunction

    function automatic t_u64 abs_word(input logic signed [31:0] v);
        if (v < 0) return t_u64'(-longint'(v));
        return t_u64'(longint'(v));
    endfunction

    // floor of the square root, one result bit per pass
    function automatic t_u64 floor_root(input t_u64 x);
        t_u64 r;
        t_u64 c;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            c = r | (t_u64'(1) << i);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    // new velocity of one axis: v plus (force + impulses) * inv_mass * dt
    function automatic logic signed [31:0] integrate_axis(input logic signed [31:0] v,
                                                          input logic signed [31:0] f,
                                                          input logic signed [31:0] p,
                                                          input logic [15:0] dt);
        longint sum;
        longint accel;
        longint dv;
        sum   = sat_word(longint'(f) + longint'(p));
        accel = (sum * longint'(m_inv_mass)) >>> vics_pkg::FRAC_W;
        dv    = (accel * longint'(dt)) >>> vics_pkg::FRAC_W;
        return sat_word(longint'(v) + dv);
    endfunction

    // scale one component back to the limit, rounding toward zero
    function automatic logic signed [31:0] rescale_axis(input logic signed [31:0] v,
                                                        input t_u64 mag);
        t_u64 q;
        q = abs_word(v) * t_u64'(m_limit) / mag;
        if (v < 0) return sat_word(-longint'(q));
        return sat_word(longint'(q));
    endfunction

    function automatic void reg_write(input logic [vics_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [31:0] d);
        case (idx)
            vics_pkg::REG_INV_MASS:    m_inv_mass = d[30:0];
            vics_pkg::REG_SPEED_LIMIT: m_limit    = d[30:0];
            vics_pkg::REG_FORCE_X:     m_force_x  = d;
            vics_pkg::REG_FORCE_Y:     m_force_y  = d;
            default: ;  // stray index leaves everything alone
        endcase
    endfunction

    // advance the body by one command; returns 1 when a result is due
    function automatic bit body_step(input vics_pkg::t_cmd cmd,
                                     input logic signed [31:0] vx,
                                     input logic signed [31:0] vy,
                                     input logic [15:0] dt,
                                     output t_motion res);
        t_u64 len2;
        t_u64 lim2;
        t_u64 mag;
        res = '0;
        if (cmd != vics_pkg::CMD_TICK) begin
            case (cmd)
                vics_pkg::CMD_IMPULSE: begin
                    imp_x = sat_word(longint'(imp_x) + longint'(vx));
                    imp_y = sat_word(longint'(imp_y) + longint'(vy));
                end
                vics_pkg::CMD_ADD_VEL: begin
                    vel_x = sat_word(longint'(vel_x) + longint'(vx));
                    vel_y = sat_word(longint'(vel_y) + longint'(vy));
                end
                default: begin
                    vel_x = '0;
                    vel_y = '0;
                end
            endcase
            return 1'b0;
        end
        vel_x = integrate_axis(vel_x, m_force_x, imp_x, dt);
        vel_y = integrate_axis(vel_y, m_force_y, imp_y, dt);
        imp_x = '0;
        imp_y = '0;
        len2 = abs_word(vel_x) * abs_word(vel_x) + abs_word(vel_y) * abs_word(vel_y);
        lim2 = t_u64'(m_limit) * t_u64'(m_limit);
        if (len2 > lim2) begin
            mag = floor_root(len2);
            if (mag == 0) mag = 1;
            vel_x = rescale_axis(vel_x, mag);
            vel_y = rescale_axis(vel_y, mag);
            res.clamped = 1'b1;
        end
        res.disp_x = sat_word((longint'(vel_x) * longint'(dt)) >>> vics_pkg::FRAC_W);
        res.disp_y = sat_word((longint'(vel_y) * longint'(dt)) >>> vics_pkg::FRAC_W);
        res.spd_x  = vel_x;
        res.spd_y  = vel_y;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_PRINT)
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, $signed(want), $signed(got));
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_motion want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (motion_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_PRINT)
                    $display("%0t: result transaction with nothing expected, speed %0d %0d",
                             $time, out_if.speed_x, out_if.speed_y);
            end else begin
                want = motion_q.pop_front();
                check_field("displacement_x", want.disp_x, out_if.displacement_x);
                check_field("displacement_y", want.disp_y, out_if.displacement_y);
                check_field("speed_x", want.spd_x, out_if.speed_x);
                check_field("speed_y", want.spd_y, out_if.speed_y);
                check_field("clamped", 32'(want.clamped), 32'(out_if.clamped));
            end
        end
    end

    // result sink with random back-pressure: short stalls mostly, a few long ones
    initial begin : result_sink
        int  hold;
        bit  rdy;
        hold = 0;
        rdy  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                if (!sink_stalls_on || $urandom_range(0, 3) != 0) begin
                    rdy  = 1'b1;
                    hold = $urandom_range(1, 12);
                end else begin
                    rdy  = 1'b0;
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                       : $urandom_range(1, 3);
                end
            end else begin
                hold--;
            end
            out_if.ready <= rdy;
        end
    end

    // watchdog: ends the run when no transaction happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, motion_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Q16.16 word: mostly modest values, some full range, some extremes
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return SMAX;
                    1:       return SMIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            1, 2:    return $urandom;
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_force();
        case ($urandom_range(0, 5))
            0:       return SMAX;
            1:       return SMIN;
            2:       return '0;
            5:       return $urandom;
            default: return int'($urandom_range(0, 524288)) - 262144;
        endcase
    endfunction

    // one input transaction; valid stays high when no gap follows
    task automatic send_cmd(input vics_pkg::t_cmd cmd, input logic signed [31:0] vx,
                            input logic signed [31:0] vy, input logic [15:0] dt);
        t_motion res;
        int      gap;
        in_if.valid      <= 1'b1;
        in_if.cmd        <= cmd;
        in_if.vec_x      <= vx;
        in_if.vec_y      <= vy;
        in_if.delta_time <= dt;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (body_step(cmd, vx, vy, dt, res)) motion_q = {motion_q, res};
        items_sent++;
        gap = pick_gap(send_gaps_on);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [vics_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        reg_write(idx, d);
    endtask

    // writes all four registers, plus a stray index when asked; the unused top bit of the unsigned ones is random
    task automatic apply_config(input logic [30:0] mass, input logic [30:0] limit,
                                input logic signed [31:0] fx, input logic signed [31:0] fy,
                                input bit stray);
        write_reg(vics_pkg::REG_INV_MASS, {$urandom_range(0, 1) == 1, mass});
        write_reg(vics_pkg::REG_SPEED_LIMIT, {$urandom_range(0, 1) == 1, limit});
        write_reg(vics_pkg::REG_FORCE_X, fx);
        write_reg(vics_pkg::REG_FORCE_Y, fy);
        if (stray)
            write_reg(vics_pkg::REG_FORCE_Y
                      + vics_pkg::CFG_IDX_W'(1 + $urandom_range(0, 251)), $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    // wait until every tick has reported, then let the pipeline settle
    task automatic wait_idle(input int settle);
        in_if.valid <= 1'b0;
        while (motion_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers at reset: massless body and zero speed limit
    task automatic test_reset_state();
        send_cmd(vics_pkg::CMD_TICK, '0, '0, 16'hFFFF);
        send_cmd(vics_pkg::CMD_ADD_VEL, ONE, -2 * ONE, 16'h1234);
        send_cmd(vics_pkg::CMD_TICK, SMAX, SMIN, 16'h8000);       // zero limit clamps to rest
        send_cmd(vics_pkg::CMD_RESET_VEL, SMAX, SMIN, 16'hFFFF);
    endtask

    // massless body: impulses and forces have no effect, velocity still moves it
    task automatic test_massless_body();
        wait_idle(IDLE_PAUSE);
        apply_config('0, UMAX, SMAX, SMIN, 1'b1);
        send_cmd(vics_pkg::CMD_ADD_VEL, 3 * ONE, -4 * ONE, '0);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, 16'h4000);
        send_cmd(vics_pkg::CMD_IMPULSE, SMAX, SMIN, 16'hFFFF);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, 16'hFFFF);
    endtask

    // saturating impulse, velocity and force sums; reset velocity keeps impulses
    task automatic test_saturation();
        wait_idle(IDLE_PAUSE);
        apply_config(UMAX, UMAX, SMAX, SMIN, 1'b0);
        send_cmd(vics_pkg::CMD_IMPULSE, SMAX, SMIN, '0);
        send_cmd(vics_pkg::CMD_IMPULSE, SMAX, SMIN, 16'hFFFF);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, 16'hFFFF);
        send_cmd(vics_pkg::CMD_ADD_VEL, SMAX, SMAX, '0);
        send_cmd(vics_pkg::CMD_ADD_VEL, SMAX, SMAX, '0);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, '0);
        send_cmd(vics_pkg::CMD_IMPULSE, SMIN, SMAX, '0);
        send_cmd(vics_pkg::CMD_RESET_VEL, -1, -1, 16'h00FF);
        send_cmd(vics_pkg::CMD_TICK, -1, -1, 16'hFFFF);
    endtask

    // limit of 5.0: exactly on the limit passes, just above it is rescaled
    task automatic test_speed_limit();
        wait_idle(IDLE_PAUSE);
        apply_config(31'h0001_0000, 31'h0005_0000, '0, '0, 1'b1);
        send_cmd(vics_pkg::CMD_ADD_VEL, 3 * ONE, 4 * ONE, '0);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, '0);
        send_cmd(vics_pkg::CMD_ADD_VEL, ONE, '0, '0);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, 16'hFFFF);
        send_cmd(vics_pkg::CMD_ADD_VEL, -8 * ONE, ONE / 4, '0);
        send_cmd(vics_pkg::CMD_TICK, '0, '0, 16'h0001);
    endtask

    // mostly impulses then a tick, with some velocity pokes and random noise
    task automatic test_random_traffic();
        int               target;
        int               n_imp;
        logic [30:0]      mass;
        logic [30:0]      limit;
        logic [15:0]      dt;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle(IDLE_PAUSE);
            case ($urandom_range(0, 5))
                0:       mass = '0;
                1:       mass = UMAX;
                2:       mass = 31'h0001_0000;
                5:       mass = 31'($urandom);
                default: mass = 31'($urandom_range(1, 262144));
            endcase
            case ($urandom_range(0, 5))
                0:       limit = '0;
                1:       limit = UMAX;
                4:       limit = 31'($urandom_range(1, 65535));
                5:       limit = 31'($urandom);
                default: limit = 31'($urandom_range(65536, 2097152));
            endcase
            apply_config(mass, limit, rand_force(), rand_force(), $urandom_range(0, 3) == 0);
            // one phase runs back to back on both sides
            send_gaps_on   = (ph != 3);
            sink_stalls_on = (ph != 3);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_cmd(vics_pkg::t_cmd'($urandom_range(0, 3)), rand_word(), rand_word(),
                             16'($urandom));
                end else begin
                    n_imp = $urandom_range(0, 3);
                    repeat (n_imp) send_cmd(vics_pkg::CMD_IMPULSE, rand_word(), rand_word(),
                                            16'($urandom));
                    if ($urandom_range(0, 4) == 0)
                        send_cmd(vics_pkg::CMD_ADD_VEL, rand_word(), rand_word(),
                                 16'($urandom));
                    if ($urandom_range(0, 19) == 0)
                        send_cmd(vics_pkg::CMD_RESET_VEL, rand_word(), rand_word(),
                                 16'($urandom));
                    case ($urandom_range(0, 9))
                        0:       dt = '0;
                        1:       dt = 16'hFFFF;
                        default: dt = 16'($urandom);
                    endcase
                    send_cmd(vics_pkg::CMD_TICK, rand_word(), rand_word(), dt);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        mismatches     = 0;
        items_sent     = 0;
        send_gaps_on   = 1'b1;
        sink_stalls_on = 1'b1;
        m_inv_mass     = '0;
        m_limit        = '0;
        m_force_x      = '0;
        m_force_y      = '0;
        vel_x          = '0;
        vel_y          = '0;
        imp_x          = '0;
        imp_y          = '0;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= vics_pkg::CMD_TICK;
        in_if.vec_x      <= '0;
        in_if.vec_y      <= '0;
        in_if.delta_time <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= vics_pkg::REG_INV_MASS;
        cfg_if.data      <= '0;
        out_if.ready     <= 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_massless_body();
        test_saturation();
        test_speed_limit();
        test_random_traffic();

        wait_idle(DRAIN_PAUSE);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
